>>> rtl/core/ppt_pkg.sv
package ppt_pkg;

   localparam int ID_W  = 16;
   localparam int PRI_W = 8;
   localparam int OP_W  = 2;
   localparam int STS_W = 2;
   localparam int OCC_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_W-1:0] OP_REM_HIGH = 2'd1;
   localparam logic [OP_W-1:0] OP_REM_LOW  = 2'd2;
   localparam logic [OP_W-1:0] OP_REM_ID   = 2'd3;

   localparam logic [STS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic take_head;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DROP = 3'b100
   } state_type;

endpackage

>>> rtl/core/process_priority_table_top.sv
// Insert, and any removal from an empty table: result strobe in the cycle after start.
// Remove by id: result after one rotation of the live entries.
// Remove highest/lowest: result after a search rotation, then a drop rotation.
// The cell chain rotates one entry per cycle past the head comparator; busy is high meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset empties the table (count to zero); cell contents are not cleared.
module process_priority_table_top #(
   parameter int CAPACITY = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ppt_pkg::OP_W-1:0]    req_opcode,
   input  logic [ppt_pkg::ID_W-1:0]    req_proc_id,
   input  logic [ppt_pkg::PRI_W-1:0]   req_proc_priority,
   output logic                        rsp_valid,
   output logic [ppt_pkg::STS_W-1:0]   rsp_status,
   output logic [ppt_pkg::ID_W-1:0]    rsp_removed_id,
   output logic [ppt_pkg::PRI_W-1:0]   rsp_removed_priority,
   output logic [ppt_pkg::OCC_W-1:0]   rsp_occupancy
);
   import ppt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [ID_W-1:0]    key_ff, key_in;
   logic [PRI_W-1:0]   best_ff, best_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [PRI_W-1:0]   rsp_pri_ff, rsp_pri_in;
   logic [OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;

   entry_type          cell_q [CAPACITY];
   entry_type          head;
   entry_type          ins_entry;
   logic               accept;
   logic               shift_en;
   logic               load_en;
   logic               match;
   logic               last_step;
   logic               found_now;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign head      = cell_q[0];
   assign ins_entry = '{id: req_proc_id, pri: req_proc_priority};
   assign last_step = (step_ff == count_ff - CNT_W'(1));

   always_comb begin
      if (op_ff == OP_REM_ID) begin
         match = !found_ff && (head.id == key_ff);
      end else begin
         match = !found_ff && (head.pri == best_ff);
      end
   end

   assign found_now = found_ff || match;

   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         cell_ctrl_type ctrl;
         entry_type     next_entry;

         assign ctrl.load      = load_en && (count_ff == CNT_W'(k));
         assign ctrl.shift     = shift_en;
         assign ctrl.take_head = (len_ff == CNT_W'(k + 1));

         if (k == CAPACITY - 1) begin : g_last
            assign next_entry = cell_q[0];
         end else begin : g_mid
            assign next_entry = cell_q[k + 1];
         end

         ppt_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .ins_entry  (ins_entry),
            .head_entry (head),
            .next_entry (next_entry),
            .cell_entry (cell_q[k])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_occ_in    = rsp_occ_ff;
      shift_en      = 1'b0;
      load_en       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = '0;
                     rsp_pri_in   = '0;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = STAT_FULL;
                        rsp_occ_in    = OCC_W'(count_ff);
                     end else begin
                        load_en       = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STAT_OK;
                        rsp_occ_in    = OCC_W'(count_ff + CNT_W'(1));
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_id_in     = '0;
                        rsp_pri_in    = '0;
                        rsp_occ_in    = '0;
                     end else begin
                        op_in    = req_opcode;
                        key_in   = req_proc_id;
                        step_in  = '0;
                        len_in   = count_ff;
                        found_in = 1'b0;
                        state_in = (req_opcode == OP_REM_ID) ? S_DROP : S_SCAN;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            shift_en = 1'b1;
            step_in  = step_ff + CNT_W'(1);
            if (step_ff == '0) begin
               best_in = head.pri;
            end else if (op_ff == OP_REM_HIGH) begin
               if (head.pri > best_ff) begin
                  best_in = head.pri;
               end
            end else begin
               if (head.pri < best_ff) begin
                  best_in = head.pri;
               end
            end
            if (last_step) begin
               step_in  = '0;
               found_in = 1'b0;
               len_in   = count_ff;
               state_in = S_DROP;
            end
         end

         S_DROP: begin
            shift_en = 1'b1;
            step_in  = step_ff + CNT_W'(1);
            if (match) begin
               found_in   = 1'b1;
               rsp_id_in  = head.id;
               rsp_pri_in = head.pri;
               len_in     = len_ff - CNT_W'(1);
            end
            if (last_step) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (found_now) begin
                  rsp_status_in = STAT_OK;
                  count_in      = count_ff - CNT_W'(1);
                  rsp_occ_in    = OCC_W'(count_ff - CNT_W'(1));
               end else begin
                  rsp_status_in = STAT_EMPTY;
                  rsp_id_in     = '0;
                  rsp_pri_in    = '0;
                  rsp_occ_in    = OCC_W'(count_ff);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         len_ff       <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_id       = rsp_id_ff;
   assign rsp_removed_priority = rsp_pri_ff;
   assign rsp_occupancy        = rsp_occ_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_busy_nonempty : assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff != '0) && (len_ff != '0))
      else $error("rotation running on an empty table");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |->
         (rsp_removed_id == '0) && (rsp_removed_priority == '0))
      else $error("failed item returned a removed entry");

   a_full_occ : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> rsp_occupancy == OCC_W'(CAPACITY))
      else $error("full status while table not full");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == S_DROP) && (state_ff == S_IDLE) |-> rsp_valid)
      else $error("removal finished without a result");

endmodule

>>> rtl/core/ppt_cell.sv
module ppt_cell (
   input  logic                  clock,
   input  ppt_pkg::cell_ctrl_type ctrl,
   input  ppt_pkg::entry_type    ins_entry,
   input  ppt_pkg::entry_type    head_entry,
   input  ppt_pkg::entry_type    next_entry,
   output ppt_pkg::entry_type    cell_entry
);
   import ppt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = ins_entry;
      end else if (ctrl.shift) begin
         entry_in = ctrl.take_head ? head_entry : next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cell_entry = entry_ff;

endmodule
